// ===== rtl/sm83_alu_pkg.sv =====
// ----------------------------------------------------------------------------
// sm83_alu_pkg
// Command codes, flag positions, adjust constants and the request and
// response beat types shared by the ALU, shift and bit unit.
// ----------------------------------------------------------------------------
package sm83_alu_pkg;

    localparam logic [4:0] CMD_ADD  = 5'd0;
    localparam logic [4:0] CMD_ADC  = 5'd1;
    localparam logic [4:0] CMD_SUB  = 5'd2;
    localparam logic [4:0] CMD_SBC  = 5'd3;
    localparam logic [4:0] CMD_AND  = 5'd4;
    localparam logic [4:0] CMD_OR   = 5'd5;
    localparam logic [4:0] CMD_XOR  = 5'd6;
    localparam logic [4:0] CMD_CP   = 5'd7;
    localparam logic [4:0] CMD_INC  = 5'd8;
    localparam logic [4:0] CMD_DEC  = 5'd9;
    localparam logic [4:0] CMD_SWAP = 5'd10;
    localparam logic [4:0] CMD_DAA  = 5'd11;
    localparam logic [4:0] CMD_CPL  = 5'd12;
    localparam logic [4:0] CMD_CCF  = 5'd13;
    localparam logic [4:0] CMD_SCF  = 5'd14;
    localparam logic [4:0] CMD_RLC  = 5'd15;
    localparam logic [4:0] CMD_RL   = 5'd16;
    localparam logic [4:0] CMD_RRC  = 5'd17;
    localparam logic [4:0] CMD_RR   = 5'd18;
    localparam logic [4:0] CMD_SLA  = 5'd19;
    localparam logic [4:0] CMD_SRA  = 5'd20;
    localparam logic [4:0] CMD_SRL  = 5'd21;
    localparam logic [4:0] CMD_BIT  = 5'd22;
    localparam logic [4:0] CMD_SET  = 5'd23;
    localparam logic [4:0] CMD_RES  = 5'd24;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [7:0] DAA_LO_ADJ  = 8'h06;
    localparam logic [7:0] DAA_HI_ADJ  = 8'h60;
    localparam logic [7:0] DAA_HI_LIM  = 8'h99;
    localparam logic [7:0] NIBBLE_LO   = 8'h0F;
    localparam logic [7:0] NIBBLE_HI   = 8'hF0;
    localparam logic [3:0] DAA_LO_LIM  = 4'd9;

    typedef struct packed {
        logic [4:0]  command;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [3:0]  bit_index;
        logic        wide;
        logic [3:0]  flags;
    } alu_req_t;

    typedef struct packed {
        logic [15:0] result;
        logic [3:0]  flags;
    } alu_rsp_t;

endpackage

// ===== rtl/sm83_alu_core.sv =====
// ----------------------------------------------------------------------------
// sm83_alu_core
// Arithmetic, logic, adjust, shift, rotate and bit datapath; one request
// beat in, one response beat out, no storage.
// ----------------------------------------------------------------------------
module sm83_alu_core
    import sm83_alu_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    always_comb
    begin
        logic        w;
        logic [15:0] a;
        logic [15:0] b;
        logic [7:0]  a8;
        logic [7:0]  b8;
        logic [3:0]  k;
        logic        z;
        logic        n;
        logic        h;
        logic        c;
        logic        cin;
        logic        top;
        logic        outb;
        logic        shift;
        logic [15:0] res;
        logic [16:0] s17;
        logic [12:0] s13;
        logic [8:0]  s9;
        logic [4:0]  s5;
        logic [7:0]  adj;

        w = req.wide & ((req.command == CMD_ADD) || (req.command == CMD_INC) ||
                        (req.command == CMD_DEC) || (req.command == CMD_SWAP) ||
                        (req.command >= CMD_RLC));
        a   = w ? req.operand_a : {8'h00, req.operand_a[7:0]};
        b   = w ? req.operand_b : {8'h00, req.operand_b[7:0]};
        a8  = a[7:0];
        b8  = b[7:0];
        k   = w ? req.bit_index : {1'b0, req.bit_index[2:0]};
        top = w ? a[15] : a[7];
        z   = req.flags[FLAG_Z];
        n   = req.flags[FLAG_N];
        h   = req.flags[FLAG_H];
        c   = req.flags[FLAG_C];
        cin = 1'b0;
        outb  = 1'b0;
        shift = 1'b0;
        res   = a;
        s17 = '0;
        s13 = '0;
        s9  = '0;
        s5  = '0;
        adj = '0;

        case (req.command)
            CMD_ADD:
            begin
                s17 = {1'b0, a} + {1'b0, b};
                n   = 1'b0;
                if (w)
                begin
                    s13 = {1'b0, a[11:0]} + {1'b0, b[11:0]};
                    h   = s13[12];
                    c   = s17[16];
                    res = s17[15:0];
                end
                else
                begin
                    s5  = {1'b0, a[3:0]} + {1'b0, b[3:0]};
                    h   = s5[4];
                    c   = s17[8];
                    res = {8'h00, s17[7:0]};
                    z   = (s17[7:0] == 8'h00);
                end
            end
            CMD_ADC:
            begin
                s9  = {1'b0, a8} + {1'b0, b8} + {8'h00, c};
                s5  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'h0, c};
                h   = s5[4];
                c   = s9[8];
                n   = 1'b0;
                res = {8'h00, s9[7:0]};
                z   = (s9[7:0] == 8'h00);
            end
            CMD_SUB, CMD_SBC, CMD_CP:
            begin
                cin = (req.command == CMD_SBC) ? c : 1'b0;
                s9  = {1'b0, a8} - {1'b0, b8} - {8'h00, cin};
                s5  = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'h0, cin};
                h   = s5[4];
                c   = s9[8];
                z   = (s9[7:0] == 8'h00);
                n   = 1'b1;
                res = (req.command == CMD_CP) ? a : {8'h00, s9[7:0]};
            end
            CMD_AND:
            begin
                res = {8'h00, a8 & b8};
                z = (res == 16'h0000); n = 1'b0; h = 1'b1; c = 1'b0;
            end
            CMD_OR:
            begin
                res = {8'h00, a8 | b8};
                z = (res == 16'h0000); n = 1'b0; h = 1'b0; c = 1'b0;
            end
            CMD_XOR:
            begin
                res = {8'h00, a8 ^ b8};
                z = (res == 16'h0000); n = 1'b0; h = 1'b0; c = 1'b0;
            end
            CMD_INC:
            begin
                res = w ? (a + 16'h0001) : {8'h00, a8 + 8'h01};
                if (!w)
                begin
                    z = (res == 16'h0000); n = 1'b0; h = ((a8 & NIBBLE_LO) == NIBBLE_LO);
                end
            end
            CMD_DEC:
            begin
                res = w ? (a - 16'h0001) : {8'h00, a8 - 8'h01};
                if (!w)
                begin
                    z = (res == 16'h0000); n = 1'b1; h = ((a8 & NIBBLE_LO) == 8'h00);
                end
            end
            CMD_SWAP:
            begin
                res = w ? {a[7:0], a[15:8]} : {8'h00, a8[3:0], a8[7:4]};
                z = (res == 16'h0000); n = 1'b0; h = 1'b0; c = 1'b0;
            end
            CMD_DAA:
            begin
                adj = 8'h00;
                if (!n)
                begin
                    if (c || (a8 > DAA_HI_LIM))
                    begin
                        adj = adj | DAA_HI_ADJ;
                        c   = 1'b1;
                    end
                    if (h || (a8[3:0] > DAA_LO_LIM))
                        adj = adj | DAA_LO_ADJ;
                    res = {8'h00, a8 + adj};
                end
                else
                begin
                    if (c)
                        adj = adj | DAA_HI_ADJ;
                    if (h)
                        adj = adj | DAA_LO_ADJ;
                    res = {8'h00, a8 - adj};
                end
                z = (res == 16'h0000); h = 1'b0;
            end
            CMD_CPL:
            begin
                res = {8'h00, ~a8}; n = 1'b1; h = 1'b1;
            end
            CMD_CCF:
            begin
                n = 1'b0; h = 1'b0; c = ~c;
            end
            CMD_SCF:
            begin
                n = 1'b0; h = 1'b0; c = 1'b1;
            end
            CMD_RLC:
            begin
                outb = top; shift = 1'b1;
                res  = w ? {a[14:0], a[15]} : {8'h00, a8[6:0], a8[7]};
            end
            CMD_RL:
            begin
                outb = top; shift = 1'b1;
                res  = w ? {a[14:0], c} : {8'h00, a8[6:0], c};
            end
            CMD_RRC:
            begin
                outb = a[0]; shift = 1'b1;
                res  = w ? {a[0], a[15:1]} : {8'h00, a8[0], a8[7:1]};
            end
            CMD_RR:
            begin
                outb = a[0]; shift = 1'b1;
                res  = w ? {c, a[15:1]} : {8'h00, c, a8[7:1]};
            end
            CMD_SLA:
            begin
                outb = top; shift = 1'b1;
                res  = w ? {a[14:0], 1'b0} : {8'h00, a8[6:0], 1'b0};
            end
            CMD_SRA:
            begin
                outb = a[0]; shift = 1'b1;
                res  = w ? {a[15], a[15:1]} : {8'h00, a8[7], a8[7:1]};
            end
            CMD_SRL:
            begin
                outb = a[0]; shift = 1'b1;
                res  = {1'b0, a[15:1]};
            end
            CMD_BIT:
            begin
                z = ~a[k]; n = 1'b0; h = 1'b1;
            end
            CMD_SET:
            begin
                res = a | (16'h0001 << k);
            end
            CMD_RES:
            begin
                res = a & ~(16'h0001 << k);
            end
            default:
            begin
                res = a;
            end
        endcase

        if (shift)
        begin
            z = (res == 16'h0000); n = 1'b0; h = 1'b0; c = outb;
        end

        rsp.result = res;
        rsp.flags  = {z, n, h, c};
    end

endmodule

// ===== rtl/sm83_alu_shift_bit_unit.sv =====
// ----------------------------------------------------------------------------
// sm83_alu_shift_bit_unit
// Execute unit for arithmetic, logic, decimal adjust, shift, rotate and bit
// commands with registered input and registered result.
// ----------------------------------------------------------------------------
// One command is accepted in every cycle: busy stays low, since the
// receiver cannot stall and nothing inside the unit ever backs up. Each
// accepted beat shows up on result and flags_out, marked by done for one
// cycle: the input register takes the beat, then the datapath loads the
// result register, and done is registered alongside it. Results come out
// in command order, one per command.
// ----------------------------------------------------------------------------
module sm83_alu_shift_bit_unit
    import sm83_alu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [4:0]  command,
    input  logic [15:0] operand_a,
    input  logic [15:0] operand_b,
    input  logic [3:0]  bit_index,
    input  logic        wide,
    input  logic [3:0]  flags_in,
    output logic        done,
    output logic [15:0] result,
    output logic [3:0]  flags_out
);

    logic     issue_reg;
    logic     issue_next;
    alu_req_t req_reg;
    alu_req_t req_next;
    logic     done_reg;
    alu_rsp_t rsp_reg;
    alu_rsp_t rsp_next;

    assign busy       = 1'b0;
    assign issue_next = start & ~busy;

    always_comb
    begin
        req_next.command   = command;
        req_next.operand_a = operand_a;
        req_next.operand_b = operand_b;
        req_next.bit_index = bit_index;
        req_next.wide      = wide;
        req_next.flags     = flags_in;
    end

    sm83_alu_core u_core
    (
        .req (req_reg),
        .rsp (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            issue_reg <= issue_next;
            done_reg  <= issue_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_next)
            req_reg <= req_next;
        if (issue_reg)
            rsp_reg <= rsp_next;
    end

    assign done      = done_reg;
    assign result    = rsp_reg.result;
    assign flags_out = rsp_reg.flags;

    a_issue_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted beat did not produce a result");

    a_done_has_issue: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(issue_reg))
        else $error("result strobe without an accepted beat");

    a_cp_keeps_a: assert property (@(posedge clk) disable iff (!rst_n)
        (issue_reg && req_reg.command == CMD_CP) |=>
            (result == {8'h00, $past(req_reg.operand_a[7:0])}))
        else $error("compare changed the operand");

    a_narrow_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (issue_reg && !req_reg.wide) |=> (result[15:8] == 8'h00))
        else $error("narrow command left a nonzero high byte");

endmodule

// ===== tb/sv/sm83_alu_shift_bit_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sm83_alu_shift_bit_unit_tb
// Self-checking bench for the SM83 ALU, shift and bit unit. A queue of
// commands feeds a clocked driver: directed corner cases first, then random
// commands in phases with different idle rates on the issue side. Every
// accepted beat is run through an in-bench flag and result model, and a
// clocked monitor compares each done beat against the oldest prediction.
// ----------------------------------------------------------------------------
module sm83_alu_shift_bit_unit_tb;

    import sm83_alu_pkg::*;

    localparam logic [4:0] CMD_UNUSED_LO = 5'd25;
    localparam logic [4:0] CMD_UNUSED_HI = 5'd31;
    localparam int unsigned RANDOM_PER_PHASE = 508;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned REPORT_MAX = 10;

    typedef struct {
        alu_req_t    req;
        int unsigned idle_after;
    } queued_cmd_t;

    typedef struct {
        alu_req_t req;
        alu_rsp_t rsp;
    } predicted_rsp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    alu_req_t    issued = '0;
    logic        busy;
    logic        done;
    logic [15:0] result;
    logic [3:0]  flags_out;

    queued_cmd_t    cmd_queue[$];
    predicted_rsp_t expected_rsp[$];
    queued_cmd_t    next_cmd;
    predicted_rsp_t oldest_rsp;
    int unsigned    idle_left = 0;
    int unsigned    mismatches = 0;
    int unsigned    cycle_count = 0;

    sm83_alu_shift_bit_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (issued.command),
        .operand_a (issued.operand_a),
        .operand_b (issued.operand_b),
        .bit_index (issued.bit_index),
        .wide      (issued.wide),
        .flags_in  (issued.flags),
        .done      (done),
        .result    (result),
        .flags_out (flags_out)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic alu_rsp_t compute_alu_rsp(alu_req_t r);
        logic [15:0] mask;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] res;
        logic [3:0]  top;
        logic [3:0]  k;
        logic        w;
        logic        z;
        logic        n;
        logic        h;
        logic        c;
        logic        outb;
        logic        shifted;
        int unsigned ua;
        int unsigned ub;
        int unsigned s;
        int unsigned cin;
        alu_rsp_t    rsp;
        w = r.wide && (r.command == CMD_ADD || r.command == CMD_INC ||
                       r.command == CMD_DEC || r.command == CMD_SWAP ||
                       r.command >= CMD_RLC);
        mask = w ? 16'hFFFF : 16'h00FF;
        top = w ? 4'd15 : 4'd7;
        a = r.operand_a & mask;
        b = r.operand_b & mask;
        ua = a;
        ub = b;
        res = a;
        k = r.bit_index & top;
        z = r.flags[FLAG_Z];
        n = r.flags[FLAG_N];
        h = r.flags[FLAG_H];
        c = r.flags[FLAG_C];
        outb = 1'b0;
        shifted = 1'b0;
        case (r.command)
            CMD_ADD:
            begin
                s = ua + ub;
                n = 1'b0;
                if (w)
                begin
                    h = ((ua & 'hFFF) + (ub & 'hFFF)) > 'hFFF;
                    c = s > 'hFFFF;
                    res = s[15:0];
                end
                else
                begin
                    h = ((ua & 'hF) + (ub & 'hF)) > 'hF;
                    c = s > 'hFF;
                    res = {8'h00, s[7:0]};
                    z = res == 16'h0000;
                end
            end
            CMD_ADC:
            begin
                cin = c;
                s = ua + ub + cin;
                h = ((ua & 'hF) + (ub & 'hF) + cin) > 'hF;
                c = s > 'hFF;
                n = 1'b0;
                res = {8'h00, s[7:0]};
                z = res == 16'h0000;
            end
            CMD_SUB, CMD_SBC, CMD_CP:
            begin
                cin = (r.command == CMD_SBC) ? c : 0;
                h = (ua & 'hF) < (ub & 'hF) + cin;
                c = ua < ub + cin;
                s = ua - ub - cin;
                res = {8'h00, s[7:0]};
                z = res == 16'h0000;
                n = 1'b1;
                if (r.command == CMD_CP)
                    res = a;
            end
            CMD_AND:
            begin
                res = a & b;
                z = res == 16'h0000;
                {n, h, c} = 3'b010;
            end
            CMD_OR:
            begin
                res = a | b;
                z = res == 16'h0000;
                {n, h, c} = 3'b000;
            end
            CMD_XOR:
            begin
                res = a ^ b;
                z = res == 16'h0000;
                {n, h, c} = 3'b000;
            end
            CMD_INC:
            begin
                res = (a + 16'd1) & mask;
                if (!w)
                begin
                    z = res == 16'h0000;
                    n = 1'b0;
                    h = a[3:0] == 4'hF;
                end
            end
            CMD_DEC:
            begin
                res = (a - 16'd1) & mask;
                if (!w)
                begin
                    z = res == 16'h0000;
                    n = 1'b1;
                    h = a[3:0] == 4'h0;
                end
            end
            CMD_SWAP:
            begin
                res = w ? {a[7:0], a[15:8]} : {8'h00, a[3:0], a[7:4]};
                z = res == 16'h0000;
                {n, h, c} = 3'b000;
            end
            CMD_DAA:
            begin
                s = ua;
                if (!n)
                begin
                    if (c || ua > DAA_HI_LIM)
                    begin
                        s = s + DAA_HI_ADJ;
                        c = 1'b1;
                    end
                    if (h || (ua & NIBBLE_LO) > DAA_LO_LIM)
                        s = s + DAA_LO_ADJ;
                end
                else
                begin
                    if (c)
                        s = s - DAA_HI_ADJ;
                    if (h)
                        s = s - DAA_LO_ADJ;
                end
                res = {8'h00, s[7:0]};
                z = res == 16'h0000;
                h = 1'b0;
            end
            CMD_CPL:
            begin
                res = ~a & 16'h00FF;
                n = 1'b1;
                h = 1'b1;
            end
            CMD_CCF:
            begin
                n = 1'b0;
                h = 1'b0;
                c = ~c;
            end
            CMD_SCF:
            begin
                {n, h, c} = 3'b001;
            end
            CMD_RLC:
            begin
                outb = a[top];
                res = ((a << 1) | {15'd0, outb}) & mask;
                shifted = 1'b1;
            end
            CMD_RL:
            begin
                outb = a[top];
                res = ((a << 1) | {15'd0, c}) & mask;
                shifted = 1'b1;
            end
            CMD_RRC:
            begin
                outb = a[0];
                res = (a >> 1) | ({15'd0, outb} << top);
                shifted = 1'b1;
            end
            CMD_RR:
            begin
                outb = a[0];
                res = (a >> 1) | ({15'd0, c} << top);
                shifted = 1'b1;
            end
            CMD_SLA:
            begin
                outb = a[top];
                res = (a << 1) & mask;
                shifted = 1'b1;
            end
            CMD_SRA:
            begin
                outb = a[0];
                res = (a >> 1) | (a & (16'd1 << top));
                shifted = 1'b1;
            end
            CMD_SRL:
            begin
                outb = a[0];
                res = a >> 1;
                shifted = 1'b1;
            end
            CMD_BIT:
            begin
                z = ~a[k];
                n = 1'b0;
                h = 1'b1;
            end
            CMD_SET:
            begin
                res = (a | (16'd1 << k)) & mask;
            end
            CMD_RES:
            begin
                res = a & ~(16'd1 << k) & mask;
            end
            default:
            begin
            end
        endcase
        if (shifted)
        begin
            z = res == 16'h0000;
            n = 1'b0;
            h = 1'b0;
            c = outb;
        end
        rsp.result = res;
        rsp.flags = {z, n, h, c};
        return rsp;
    endfunction

    function automatic logic [15:0] pick_operand();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h00FF;
            3: return 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_cmd(input logic [4:0] cmd, input logic [15:0] a,
                             input logic [15:0] b, input logic [3:0] idx,
                             input logic w, input logic [3:0] f,
                             input int unsigned idle);
        queued_cmd_t q;
        q.req.command = cmd;
        q.req.operand_a = a;
        q.req.operand_b = b;
        q.req.bit_index = idx;
        q.req.wide = w;
        q.req.flags = f;
        q.idle_after = idle;
        cmd_queue.push_back(q);
    endtask

    task automatic queue_random(input int unsigned idle_pct);
        logic [4:0]  cmd;
        int unsigned idle;
        if ($urandom_range(99) < 6)
            cmd = 5'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
        else
            cmd = 5'($urandom_range(CMD_RES, CMD_ADD));
        idle = 0;
        while ($urandom_range(99) < idle_pct)
            idle++;
        queue_cmd(cmd, pick_operand(), pick_operand(), 4'($urandom_range(15)),
                  1'($urandom_range(1)), 4'($urandom_range(15)), idle);
    endtask

    // issue side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            issued <= '0;
            idle_left = 0;
        end
        else
        begin
            if (start && !busy)
                expected_rsp.push_back('{issued, compute_alu_rsp(issued)});
            if (!start || !busy)
            begin
                if (idle_left != 0)
                begin
                    idle_left = idle_left - 1;
                    start <= 1'b0;
                end
                else if (cmd_queue.size() != 0)
                begin
                    next_cmd = cmd_queue.pop_front();
                    idle_left = next_cmd.idle_after;
                    issued <= next_cmd.req;
                    start <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected beat: result %h flags %b", result, flags_out);
            end
            else
            begin
                oldest_rsp = expected_rsp.pop_front();
                if (result !== oldest_rsp.rsp.result ||
                    flags_out !== oldest_rsp.rsp.flags)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch: cmd %0d a %h b %h idx %0d wide %b flags %b: %s",
                                 oldest_rsp.req.command, oldest_rsp.req.operand_a,
                                 oldest_rsp.req.operand_b, oldest_rsp.req.bit_index,
                                 oldest_rsp.req.wide, oldest_rsp.req.flags,
                                 $sformatf("expected %h/%b, got %h/%b",
                                           oldest_rsp.rsp.result, oldest_rsp.rsp.flags,
                                           result, flags_out));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int unsigned idle_pct[3];
        idle_pct = '{0, 82, 24};

        queue_cmd(CMD_ADD, 16'hABFF, 16'h1201, 4'd0, 1'b0, 4'h0, 0);
        queue_cmd(CMD_ADD, 16'h0FFF, 16'hF001, 4'd0, 1'b1, 4'h8, 0);
        queue_cmd(CMD_ADD, 16'hFFFF, 16'hFFFF, 4'd15, 1'b1, 4'hF, 0);
        queue_cmd(CMD_ADC, 16'h000F, 16'h00F0, 4'd0, 1'b0, 4'h1, 0);
        queue_cmd(CMD_SUB, 16'hFF00, 16'h0001, 4'd0, 1'b1, 4'h0, 0);
        queue_cmd(CMD_SBC, 16'h0010, 16'h000F, 4'd0, 1'b0, 4'h1, 0);
        queue_cmd(CMD_CP,  16'h0042, 16'h0042, 4'd0, 1'b0, 4'h0, 0);
        queue_cmd(CMD_AND, 16'hFFFF, 16'h0000, 4'd0, 1'b1, 4'hF, 0);
        queue_cmd(CMD_XOR, 16'h00FF, 16'h00FF, 4'd0, 1'b0, 4'h0, 0);
        queue_cmd(CMD_INC, 16'h000F, 16'h0000, 4'd0, 1'b0, 4'h1, 0);
        queue_cmd(CMD_INC, 16'hFFFF, 16'h0000, 4'd0, 1'b1, 4'hF, 0);
        queue_cmd(CMD_DEC, 16'h0000, 16'h0000, 4'd0, 1'b0, 4'h0, 0);
        queue_cmd(CMD_DEC, 16'h0000, 16'h0000, 4'd0, 1'b1, 4'h5, 0);
        queue_cmd(CMD_SWAP, 16'h1234, 16'h0000, 4'd0, 1'b1, 4'hF, 0);
        queue_cmd(CMD_DAA, 16'h009A, 16'h0000, 4'd0, 1'b0, 4'h0, 0);
        queue_cmd(CMD_DAA, 16'h0000, 16'h0000, 4'd0, 1'b0, 4'h7, 0);
        queue_cmd(CMD_CPL, 16'hFF5A, 16'h0000, 4'd0, 1'b1, 4'h0, 0);
        queue_cmd(CMD_CCF, 16'h0033, 16'h0000, 4'd0, 1'b0, 4'h7, 0);
        queue_cmd(CMD_SCF, 16'h0000, 16'h0000, 4'd0, 1'b0, 4'h6, 0);
        queue_cmd(CMD_RLC, 16'h0080, 16'h0000, 4'd0, 1'b0, 4'h0, 0);
        queue_cmd(CMD_RR,  16'h0001, 16'h0000, 4'd0, 1'b1, 4'h1, 0);
        queue_cmd(CMD_SRA, 16'h8001, 16'h0000, 4'd0, 1'b1, 4'h0, 0);
        queue_cmd(CMD_BIT, 16'h0080, 16'h0000, 4'd15, 1'b0, 4'h0, 0);
        queue_cmd(CMD_SET, 16'h0000, 16'h0000, 4'd8, 1'b0, 4'h0, 0);
        queue_cmd(CMD_RES, 16'hFFFF, 16'h0000, 4'd15, 1'b1, 4'hF, 0);
        queue_cmd(CMD_UNUSED_LO, 16'hBEEF, 16'h1234, 4'd3, 1'b1, 4'hA, 0);
        queue_cmd(CMD_UNUSED_HI, 16'hBEEF, 16'h1234, 4'd3, 1'b0, 4'h5, 0);
        foreach (idle_pct[p])
            for (int unsigned i = 0; i < RANDOM_PER_PHASE; i++)
                queue_random(idle_pct[p]);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while (cmd_queue.size() != 0 || start || expected_rsp.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
